FILE: rtl/core/hsv_to_rgb_pixel_macros.svh
// Assertion macros for the HSV to RGB pixel converter.
// Included by the top level; depends on nothing else.
`ifndef HSV_TO_RGB_PIXEL_MACROS_SVH
`define HSV_TO_RGB_PIXEL_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define H2R_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define H2R_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/h2r_pkg.sv
// Shared constants and types for the HSV to RGB pixel converter.
// No dependencies; compiled first.
package h2r_pkg;

   localparam logic [7:0]  HUE_LIMIT   = 8'd180;
   localparam logic [11:0] REGION_MUL  = 12'd2185;
   localparam logic [4:0]  REGION_SPAN = 5'd30;
   localparam logic [7:0]  FULL_SCALE  = 8'd255;

   // Sixty-degree hue sector; codes six and seven never occur.
   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } sector_type;

endpackage

FILE: rtl/core/h2r_req_if.sv
// Input channel of the converter: handshake plus one HSV pixel item.
// No dependencies.
interface h2r_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;
   logic       frame_start;
   logic       line_end;

   modport source (output valid, hue, saturation, brightness, frame_start, line_end,
                   input ready);
   modport sink   (input valid, hue, saturation, brightness, frame_start, line_end,
                   output ready);
endinterface

FILE: rtl/core/h2r_rsp_if.sv
// Result channel of the converter: handshake plus one RGB pixel item.
// No dependencies.
interface h2r_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_start_out;
   logic       line_end_out;

   modport source (output valid, red, green, blue, frame_start_out, line_end_out,
                   input ready);
   modport sink   (input valid, red, green, blue, frame_start_out, line_end_out,
                   output ready);
endinterface

FILE: rtl/core/h2r_scale.sv
// Scales one 8-bit value by another, (a*b)/255 with the rounding shortcut.
// No dependencies.
module h2r_scale (
   input  logic [7:0] a,
   input  logic [7:0] b,
   output logic [7:0] y
);
   logic [15:0] prod;
   logic [16:0] sum;

   // x/255 is taken as (x + 1 + (x >> 8)) >> 8, kept to eight bits.
   assign prod = {8'd0, a} * {8'd0, b};
   assign sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
   assign y    = sum[15:8];
endmodule

FILE: rtl/core/hsv_to_rgb_pixel.sv
// Top level of the HSV to RGB pixel converter: a four-stage pipeline.
// Depends on h2r_pkg, h2r_req_if, h2r_rsp_if, h2r_scale and the macro header.
//
//   channel   direction  handshake          item
//   req_port  in         valid/ready        hue, saturation, brightness, sideband
//   rsp_port  out        valid/ready        red, green, blue, sideband
//
// One item enters per cycle while the result is taken or the output is empty;
// the four register stages all move together on one shared enable.
// Reset is synchronous and clears only the stage valid bits.
// When the result is not taken, every stage holds, so nothing is lost or repeated.
`include "hsv_to_rgb_pixel_macros.svh"

module hsv_to_rgb_pixel (
   input logic clock,
   input logic reset,
   h2r_req_if.sink   req_port,
   h2r_rsp_if.source rsp_port
);
   import h2r_pkg::*;

   // The whole pipeline advances when the output register is empty or drained.
   logic advance;

   // Stage 1: clamped hue and its sector.
   logic       s1_valid_ff, s1_valid_in;
   sector_type s1_sector_ff, s1_sector_in;
   logic [7:0] s1_hue_ff, s1_hue_in;
   logic [7:0] s1_sat_ff, s1_val_ff;
   logic       s1_fs_ff, s1_le_ff;

   // Stage 2: fraction inside the sector and the p term.
   logic       s2_valid_ff;
   sector_type s2_sector_ff;
   logic [7:0] s2_frac_ff, s2_frac_in;
   logic [7:0] s2_p_ff, s2_p_in;
   logic [7:0] s2_sat_ff, s2_val_ff;
   logic       s2_fs_ff, s2_le_ff;

   // Stage 3: saturation scaled by the fraction and by its complement.
   logic       s3_valid_ff;
   sector_type s3_sector_ff;
   logic [7:0] s3_sf_ff, s3_sf_in;
   logic [7:0] s3_snf_ff, s3_snf_in;
   logic [7:0] s3_p_ff, s3_val_ff;
   logic       s3_grey_ff;
   logic       s3_fs_ff, s3_le_ff;

   // Stage 4: q and t, then the sector multiplexer into the output register.
   logic       out_valid_ff;
   logic [7:0] q_term, t_term;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic       out_fs_ff, out_le_ff;

   // Scratch values for the combinational parts.
   logic [19:0] hue_prod;
   logic [7:0]  sector_base;
   logic [7:0]  hue_rem;
   logic [10:0] frac_wide;

   assign advance        = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;
   assign s1_valid_in    = req_port.valid;

   // Hue of 180 or more counts as red; the sector is hue*2185 >> 16.
   always_comb begin
      s1_hue_in    = (req_port.hue >= HUE_LIMIT) ? 8'd0 : req_port.hue;
      hue_prod     = {12'd0, s1_hue_in} * {8'd0, REGION_MUL};
      s1_sector_in = sector_type'(hue_prod[18:16]);
   end

   // The offset into the 30-step sector times 8.5 gives the fraction.
   always_comb begin
      sector_base = {5'd0, s1_sector_ff} * {3'd0, REGION_SPAN};
      hue_rem     = s1_hue_ff - sector_base;
      frac_wide   = {hue_rem, 3'b000} + {4'd0, hue_rem[7:1]};
      s2_frac_in  = frac_wide[7:0];
   end

   h2r_scale u_scale_p (
      .a (s1_val_ff),
      .b (FULL_SCALE - s1_sat_ff),
      .y (s2_p_in)
   );

   h2r_scale u_scale_sf (
      .a (s2_sat_ff),
      .b (s2_frac_ff),
      .y (s3_sf_in)
   );

   h2r_scale u_scale_snf (
      .a (s2_sat_ff),
      .b (FULL_SCALE - s2_frac_ff),
      .y (s3_snf_in)
   );

   h2r_scale u_scale_q (
      .a (s3_val_ff),
      .b (FULL_SCALE - s3_sf_ff),
      .y (q_term)
   );

   h2r_scale u_scale_t (
      .a (s3_val_ff),
      .b (FULL_SCALE - s3_snf_ff),
      .y (t_term)
   );

   // Each sector places brightness, p, q and t on the three channels.
   // With zero saturation all three channels are the brightness.
   always_comb begin
      red_in   = s3_val_ff;
      green_in = s3_val_ff;
      blue_in  = s3_val_ff;
      if (!s3_grey_ff) begin
         case (s3_sector_ff)
            SECTOR_RED: begin
               green_in = t_term;
               blue_in  = s3_p_ff;
            end
            SECTOR_YELLOW: begin
               red_in  = q_term;
               blue_in = s3_p_ff;
            end
            SECTOR_GREEN: begin
               red_in  = s3_p_ff;
               blue_in = t_term;
            end
            SECTOR_CYAN: begin
               red_in   = s3_p_ff;
               green_in = q_term;
            end
            SECTOR_BLUE: begin
               red_in   = t_term;
               green_in = s3_p_ff;
            end
            default: begin
               green_in = s3_p_ff;
               blue_in  = q_term;
            end
         endcase
      end
   end

   // Valid bits: cleared by reset, moved on the shared enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sector_ff <= s1_sector_in;
         s1_hue_ff    <= s1_hue_in;
         s1_sat_ff    <= req_port.saturation;
         s1_val_ff    <= req_port.brightness;
         s1_fs_ff     <= req_port.frame_start;
         s1_le_ff     <= req_port.line_end;

         s2_sector_ff <= s1_sector_ff;
         s2_frac_ff   <= s2_frac_in;
         s2_p_ff      <= s2_p_in;
         s2_sat_ff    <= s1_sat_ff;
         s2_val_ff    <= s1_val_ff;
         s2_fs_ff     <= s1_fs_ff;
         s2_le_ff     <= s1_le_ff;

         s3_sector_ff <= s2_sector_ff;
         s3_sf_ff     <= s3_sf_in;
         s3_snf_ff    <= s3_snf_in;
         s3_p_ff      <= s2_p_ff;
         s3_val_ff    <= s2_val_ff;
         s3_grey_ff   <= (s2_sat_ff == 8'd0);
         s3_fs_ff     <= s2_fs_ff;
         s3_le_ff     <= s2_le_ff;

         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         out_fs_ff    <= s3_fs_ff;
         out_le_ff    <= s3_le_ff;
      end
   end

   assign rsp_port.valid           = out_valid_ff;
   assign rsp_port.red             = red_ff;
   assign rsp_port.green           = green_ff;
   assign rsp_port.blue            = blue_ff;
   assign rsp_port.frame_start_out = out_fs_ff;
   assign rsp_port.line_end_out    = out_le_ff;

   // A held result must also hold the input side.
   `H2R_ASSERT(a_stall_blocks_input,
      (rsp_port.valid && !rsp_port.ready) |-> !req_port.ready,
      "input accepted while result stalled")
   // An item in the last stage reaches the output when the pipeline moves.
   `H2R_ASSERT(a_last_stage_delivers,
      (s3_valid_ff && advance) |=> rsp_port.valid,
      "item lost before output")
   // The sector computed from a clamped hue never goes past magenta.
   `H2R_ASSERT(a_sector_range,
      s1_valid_ff |-> (s1_sector_ff <= SECTOR_MAGENTA),
      "hue sector out of range")
   // Reset empties the output register.
   `H2R_ASSERT_ALWAYS(a_reset_clears_output,
      reset |=> !rsp_port.valid,
      "output valid after reset")

endmodule

FILE: dv/h2r_pixel_checker.sv
// Scoreboard for the HSV to RGB pixel converter: watches both channels,
// predicts every RGB item and compares it. Depends on h2r_pkg, h2r_req_if, h2r_rsp_if.
module h2r_pixel_checker (
   input  logic clock,
   input  logic reset,
   h2r_req_if   req_mon,
   h2r_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import h2r_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
      logic       line_end;
   } rgb_pixel_type;

   rgb_pixel_type expected_pixels[$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   // Division by 255 as the hardware does it: (x + 1 + (x >> 8)) >> 8.
   function automatic logic [7:0] scale255(input int unsigned x);
      return 8'((x + 32'd1 + (x >> 8)) >> 8);
   endfunction

   function automatic rgb_pixel_type convert_pixel(input logic [7:0] hue,
                                                   input logic [7:0] sat,
                                                   input logic [7:0] bri, input logic fs,
                                                   input logic le);
      int unsigned   h, s, v, rem, f;
      logic [7:0]    p, q, t, sf, snf;
      sector_type    sector;
      rgb_pixel_type px;
      h = (hue >= HUE_LIMIT) ? 0 : hue;
      s = sat;
      v = bri;
      px.red         = bri;
      px.green       = bri;
      px.blue        = bri;
      px.frame_start = fs;
      px.line_end    = le;
      if (s != 0) begin
         sector = sector_type'(3'((h * REGION_MUL) >> 16));
         rem    = h - 32'(sector) * 32'(REGION_SPAN);
         f      = ((rem << 3) + (rem >> 1)) & 32'hFF;
         p      = scale255(v * (32'(FULL_SCALE) - s));
         sf     = scale255(s * f);
         q      = scale255(v * (32'(FULL_SCALE) - 32'(sf)));
         snf    = scale255(s * (32'(FULL_SCALE) - f));
         t      = scale255(v * (32'(FULL_SCALE) - 32'(snf)));
         case (sector)
            SECTOR_RED: begin
               px.green = t;
               px.blue  = p;
            end
            SECTOR_YELLOW: begin
               px.red  = q;
               px.blue = p;
            end
            SECTOR_GREEN: begin
               px.red  = p;
               px.blue = t;
            end
            SECTOR_CYAN: begin
               px.red   = p;
               px.green = q;
            end
            SECTOR_BLUE: begin
               px.red   = t;
               px.green = p;
            end
            default: begin
               px.green = p;
               px.blue  = q;
            end
         endcase
      end
      return px;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want, got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_pixels.push_back(convert_pixel(req_mon.hue, req_mon.saturation,
                                                    req_mon.brightness, req_mon.frame_start,
                                                    req_mon.line_end));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.red, rsp_mon.green, rsp_mon.blue,
                    rsp_mon.frame_start_out, rsp_mon.line_end_out};
            if (expected_pixels.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected item rgb=%02h %02h %02h fs=%b le=%b", $realtime,
                           got.red, got.green, got.blue, got.frame_start, got.line_end);
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.frame_start !== want.frame_start ||
                   got.line_end !== want.line_end) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch expected rgb=%02h %02h %02h fs=%b le=%b,",
                              $realtime, want.red, want.green, want.blue, want.frame_start,
                              want.line_end,
                              " got rgb=%02h %02h %02h fs=%b le=%b",
                              got.red, got.green, got.blue, got.frame_start,
                              got.line_end);
               end
            end
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

FILE: dv/tb.sv
// Top of the HSV to RGB pixel converter testbench: clock, reset, pixel stimulus,
// result back-pressure and the verdict. Depends on the RTL and h2r_pixel_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The block has four register stages; the drain wait covers anything
   // still in flight after the last expected item has come back.
   localparam int PIPE_DRAIN       = 8;
   // Length of the one long receiver hold-off that fills the pipeline.
   localparam int LONG_HOLD_CYCLES = 200;

   logic clock = 1'b0;
   logic reset;

   int mismatch_count;
   int outstanding;

   // Pacing knobs; the stimulus writes its rates and hold requests only between the falling and rising edge.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          hold_asked     = 0;
   int          hold_served    = 0;

   h2r_req_if req_bus ();
   h2r_rsp_if rsp_bus ();

   hsv_to_rgb_pixel dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   h2r_pixel_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver side. Normally ready is drawn at random against the stall rate.
   // When the stimulus asks for a long hold-off, ready is held low through it,
   // so the pipeline fills up and must stall its input.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_served = hold_served + 1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offers one pixel item and returns at the rising edge that accepts it.
   // Ready only changes at rising edges, so it is sampled at the falling edge
   // in between; a high value there means the next rising edge takes the item.
   // Valid stays high into the next item unless an idle gap is drawn.
   task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] bri, input logic fs, input logic le);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.hue         <= hue;
      req_bus.saturation  <= sat;
      req_bus.brightness  <= bri;
      req_bus.frame_start <= fs;
      req_bus.line_end    <= le;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   // Changes the idle and stall rates. Valid is lowered first so the item
   // just accepted is not offered a second time while the knobs change.
   task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct,
                           input bit long_hold);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (long_hold)
         hold_asked = hold_asked + 1;
      @(posedge clock);
   endtask

   // Random pixels: mostly hues in the valid range, with a share above it, and
   // saturation and brightness biased toward their extremes now and then.
   task automatic run_random_phase(input int count, input int unsigned send_pct,
                                   input int unsigned recv_pct, input bit long_hold);
      logic [7:0]  hue, sat, bri;
      logic        fs, le;
      int unsigned pick;
      set_pace(send_pct, recv_pct, long_hold);
      repeat (count) begin
         pick = $urandom_range(99);
         hue  = (pick < 12) ? 8'($urandom_range(255, 180)) : 8'($urandom_range(179, 0));
         pick = $urandom_range(99);
         sat  = (pick < 10) ? 8'd0 : (pick < 20) ? 8'd255 : 8'($urandom);
         pick = $urandom_range(99);
         bri  = (pick < 5) ? 8'd0 : (pick < 10) ? 8'd255 : 8'($urandom);
         fs   = ($urandom_range(15) == 0);
         le   = ($urandom_range(7) == 0);
         send_pixel(hue, sat, bri, fs, le);
      end
   endtask

   initial begin
      logic [7:0] edge_hues[12];
      int         guard;
      edge_hues = '{8'd0, 8'd29, 8'd30, 8'd59, 8'd60, 8'd89,
                    8'd90, 8'd119, 8'd120, 8'd149, 8'd150, 8'd179};

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.hue         <= 8'd0;
      req_bus.saturation  <= 8'd0;
      req_bus.brightness  <= 8'd0;
      req_bus.frame_start <= 1'b0;
      req_bus.line_end    <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, back to back. First both ends of every sixty-degree
      // sector at full saturation and brightness, walking the sideband bits.
      for (int i = 0; i < 12; i++)
         send_pixel(edge_hues[i], 8'd255, 8'd255, i[0], i[1]);
      // Hues past the end of the scale must behave like hue zero.
      send_pixel(8'd180, 8'd255, 8'd255, 1'b1, 1'b1);
      send_pixel(8'd255, 8'd200, 8'd160, 1'b0, 1'b0);
      // Zero saturation gives grey regardless of hue, in or out of range.
      send_pixel(8'd77, 8'd0, 8'd200, 1'b1, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
      send_pixel(8'd179, 8'd0, 8'd255, 1'b0, 1'b0);
      // Black, the weakest non-zero saturation and a mid-scale pixel.
      send_pixel(8'd45, 8'd255, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd100, 8'd1, 8'd255, 1'b1, 1'b1);
      send_pixel(8'd15, 8'd128, 8'd128, 1'b0, 1'b1);
      send_pixel(8'd135, 8'd170, 8'd85, 1'b1, 1'b0);

      // Random part under four pacing regimes.
      run_random_phase(150, 0, 0, 1'b0);
      run_random_phase(150, 46, 0, 1'b0);
      run_random_phase(150, 0, 46, 1'b0);
      run_random_phase(150, 35, 35, 1'b0);
      // Pressure: the receiver holds off for a long stretch while items keep
      // coming, so the pipeline fills and the input is stalled.
      run_random_phase(50, 0, 0, 1'b1);

      req_bus.valid <= 1'b0;
      guard = 0;
      @(negedge clock);
      while (outstanding != 0 && guard < 100000) begin
         @(negedge clock);
         guard = guard + 1;
      end
      repeat (PIPE_DRAIN) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("hsv_to_rgb_pixel regression: pass");
      end else begin
         $display("hsv_to_rgb_pixel regression: fail");
      end
      $finish;
   end

   // Watchdog: the whole run needs well under a tenth of this.
   initial begin
      #2ms;
      $display("hsv_to_rgb_pixel regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/h2r_pkg.sv
rtl/core/h2r_req_if.sv
rtl/core/h2r_rsp_if.sv
rtl/core/h2r_scale.sv
rtl/core/hsv_to_rgb_pixel.sv
dv/h2r_pixel_checker.sv
dv/tb.sv
